// ===== hw/rtl/gcpf_pkg.sv =====
package gcpf_pkg;

    // Data words are signed two's complement with FRAC_BITS fraction bits.
    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;

    // step_time is unsigned Q0.16 and blend_weight unsigned Q1.16, regardless of FRAC_BITS.
    localparam int Q_BITS   = 16;
    localparam int STEP_W   = 16;
    localparam int GATE_W   = 24;
    localparam int WEIGHT_W = 17;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_BYPASS       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TIME    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GATE_LIMIT   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_WEIGHT = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]   STEP_RESET   = 16'd1092;
    localparam logic [GATE_W-1:0]   GATE_RESET   = GATE_W'((64'd12 << FRAC_BITS) / 64'd10);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd42598;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO  = 17'd0;

    // Four filtered axes: x, y, z and yaw.
    localparam int LANES = 4;

    // Digit-serial multiplier geometry. The multiplier operand (step time or
    // weight) is consumed one digit per cycle, least significant first.
    localparam int DIGIT_W  = 4;
    localparam int DIGITS   = (WEIGHT_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MPLIER_W = DIGITS * DIGIT_W;
    localparam int CNT_W    = $clog2(DIGITS);
    localparam int ACC_W    = WORD_W + 1 + WEIGHT_W;
    localparam int Q_HALF   = 1 << (Q_BITS - 1);

    typedef struct packed {
        logic signed [WORD_W-1:0] meas_x;
        logic signed [WORD_W-1:0] meas_y;
        logic signed [WORD_W-1:0] meas_z;
        logic signed [WORD_W-1:0] meas_yaw;
        logic signed [WORD_W-1:0] meas_roll;
        logic signed [WORD_W-1:0] meas_pitch;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] vel_z;
        logic signed [WORD_W-1:0] yaw_rate;
        logic                     restart;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] est_x_out;
        logic signed [WORD_W-1:0] est_y_out;
        logic signed [WORD_W-1:0] est_z_out;
        logic signed [WORD_W-1:0] est_yaw_out;
        logic signed [WORD_W-1:0] roll_out;
        logic signed [WORD_W-1:0] pitch_out;
        logic                     rejected;
    } out_item_t;

endpackage

// ===== hw/rtl/gated_complementary_pose_filter.sv =====
// Gated complementary pose filter.
//
// The input channel (in_valid, in_stall, in_data) carries one beat per
// observer tick: the measured pose, the rates of x, y, z and yaw, and a
// restart request. The output channel (out_valid, out_stall, out_data)
// returns one beat per input beat with the new estimate, roll and pitch
// copied through, and a flag for a measurement the gate rejected.
// Configuration is written through cfg_we, cfg_index and cfg_data; the
// user must write it only while the block is idle, which the block itself does not enforce.
//
// The block takes no new input beat until the current one is committed
// and it is back in its idle state, where the next beat is taken. Each
// axis has one digit-serial multiplier, shared by both products of a tick
// (rate times step time, then difference times weight) at 4 bits of the
// multiplier operand per cycle. Between the two the prediction is added
// and saturated and the difference formed; after them the result is committed.
// The result sits in an output register, so a stalled receiver does not
// stop the next tick from being computed; only the final commit waits.
// Reset clears the estimate to zero, loads the default configuration and
// arms a restart, so the first tick seeds the estimate from its measurement.
module gated_complementary_pose_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  gcpf_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output gcpf_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [gcpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gcpf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int W        = gcpf_pkg::WORD_W;
    localparam int LANES    = gcpf_pkg::LANES;
    localparam int ACC_W    = gcpf_pkg::ACC_W;
    localparam int DIGIT_W  = gcpf_pkg::DIGIT_W;
    localparam int MPLIER_W = gcpf_pkg::MPLIER_W;
    localparam int CNT_W    = gcpf_pkg::CNT_W;
    localparam int Q_BITS   = gcpf_pkg::Q_BITS;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(gcpf_pkg::DIGITS - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_PRED = 3'd2;
    localparam logic [2:0] S_DIFF = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    typedef logic signed [W-1:0]     word_t;
    typedef logic signed [W:0]       wide_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // Control and architectural state.
    logic [2:0]                         state_reg, state_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic                               pending_reg, pending_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               bypass_reg, bypass_next;
    logic [gcpf_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [gcpf_pkg::GATE_W-1:0]        gate_reg, gate_next;
    logic [gcpf_pkg::WEIGHT_W-1:0]      weight_reg, weight_next;
    word_t                              est_reg [LANES];
    word_t                              est_next [LANES];

    // Working registers of the current tick.
    word_t                              meas_reg [LANES];
    word_t                              meas_next [LANES];
    acc_t                               acc_reg [LANES];
    acc_t                               acc_next [LANES];
    acc_t                               mcand_reg [LANES];
    acc_t                               mcand_next [LANES];
    word_t                              pred_reg [LANES];
    word_t                              pred_next [LANES];
    logic [MPLIER_W-1:0]                mplier_reg, mplier_next;
    word_t                              roll_reg, roll_next;
    word_t                              pitch_reg, pitch_next;
    logic                               restart_reg, restart_next;
    logic                               rej_reg, rej_next;
    logic [gcpf_pkg::WEIGHT_W-1:0]      w_reg, w_next;
    gcpf_pkg::out_item_t                out_data_reg, out_data_next;

    // Per-lane datapath signals.
    word_t                              in_meas [LANES];
    word_t                              in_rate [LANES];
    logic [DIGIT_W-1:0]                 digit;
    acc_t                               partial [LANES];
    acc_t                               rounded [LANES];
    word_t                              scaled [LANES];
    wide_t                              pred_sum [LANES];
    word_t                              pred_sat [LANES];
    wide_t                              gate_diff [LANES];
    logic [W:0]                         gate_mag [LANES];
    logic [LANES-1:0]                   gate_over;
    wide_t                              blend_diff [LANES];
    word_t                              new_est [LANES];
    logic [gcpf_pkg::WEIGHT_W-1:0]      weight_clamped;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign digit = mplier_reg[DIGIT_W-1:0];
    assign weight_clamped = (weight_reg > gcpf_pkg::WEIGHT_ONE) ? gcpf_pkg::WEIGHT_ONE
                                                                 : weight_reg;

    always_comb
    begin
        in_meas[0] = in_data.meas_x;
        in_meas[1] = in_data.meas_y;
        in_meas[2] = in_data.meas_z;
        in_meas[3] = in_data.meas_yaw;
        in_rate[0] = in_data.vel_x;
        in_rate[1] = in_data.vel_y;
        in_rate[2] = in_data.vel_z;
        in_rate[3] = in_data.yaw_rate;
    end

    // Lane arithmetic. Each lane owns one digit-serial multiplier; the
    // multiplier operand is common to all lanes and shifts right one digit
    // per cycle while each multiplicand shifts left by the same amount.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            partial[i]  = acc_t'(mcand_reg[i] * $signed({1'b0, digit}));
            // Round half up, then drop the Q0.16 fraction of the weight or step.
            rounded[i]  = acc_reg[i] + acc_t'(gcpf_pkg::Q_HALF);
            scaled[i]   = rounded[i][Q_BITS +: W];
            pred_sum[i] = {est_reg[i][W-1], est_reg[i]} + {scaled[i][W-1], scaled[i]};
            if (pred_sum[i][W] != pred_sum[i][W-1])
            begin
                pred_sat[i] = pred_sum[i][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                pred_sat[i] = pred_sum[i][W-1:0];
            end
            gate_diff[i]  = {meas_reg[i][W-1], meas_reg[i]} - {est_reg[i][W-1], est_reg[i]};
            gate_mag[i]   = gate_diff[i][W] ? (W + 1)'(-gate_diff[i]) : gate_diff[i];
            gate_over[i]  = gate_mag[i] > (W + 1)'(gate_reg);
            blend_diff[i] = {pred_reg[i][W-1], pred_reg[i]} - {meas_reg[i][W-1], meas_reg[i]};
            // The blend always lies between measurement and prediction, so
            // the low word of the sum is exact.
            new_est[i]    = meas_reg[i] + scaled[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        bypass_next    = bypass_reg;
        step_next      = step_reg;
        gate_next      = gate_reg;
        weight_next    = weight_reg;
        mplier_next    = mplier_reg;
        roll_next      = roll_reg;
        pitch_next     = pitch_reg;
        restart_next   = restart_reg;
        rej_next       = rej_reg;
        w_next         = w_reg;
        out_data_next  = out_data_reg;
        for (int i = 0; i < LANES; i++)
        begin
            est_next[i]   = est_reg[i];
            meas_next[i]  = meas_reg[i];
            acc_next[i]   = acc_reg[i];
            mcand_next[i] = mcand_reg[i];
            pred_next[i]  = pred_reg[i];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                gcpf_pkg::CFG_BYPASS:       bypass_next = cfg_data[0];
                gcpf_pkg::CFG_STEP_TIME:    step_next   = cfg_data[gcpf_pkg::STEP_W-1:0];
                gcpf_pkg::CFG_GATE_LIMIT:   gate_next   = cfg_data[gcpf_pkg::GATE_W-1:0];
                gcpf_pkg::CFG_BLEND_WEIGHT: weight_next = cfg_data[gcpf_pkg::WEIGHT_W-1:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // A restart request or the armed restart after reset
                    // seeds the estimate from this measurement.
                    restart_next = in_data.restart | pending_reg;
                    pending_next = 1'b0;
                    roll_next    = in_data.meas_roll;
                    pitch_next   = in_data.meas_pitch;
                    mplier_next  = MPLIER_W'(step_reg);
                    cnt_next     = '0;
                    for (int i = 0; i < LANES; i++)
                    begin
                        meas_next[i]  = in_meas[i];
                        mcand_next[i] = acc_t'(in_rate[i]);
                        acc_next[i]   = '0;
                    end
                    state_next = S_MUL1;
                end
            end
            S_MUL1, S_MUL2:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    acc_next[i]   = acc_reg[i] + partial[i];
                    mcand_next[i] = mcand_reg[i] <<< DIGIT_W;
                end
                mplier_next = mplier_reg >> DIGIT_W;
                // The gate compares against the previous estimate, which
                // stays untouched until the commit.
                if (state_reg == S_MUL1 && cnt_reg == '0)
                begin
                    if (restart_reg)
                    begin
                        rej_next = 1'b0;
                        w_next   = gcpf_pkg::WEIGHT_ZERO;
                    end
                    else if (|gate_over)
                    begin
                        rej_next = 1'b1;
                        w_next   = gcpf_pkg::WEIGHT_ONE;
                    end
                    else
                    begin
                        rej_next = 1'b0;
                        w_next   = weight_clamped;
                    end
                end
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = (state_reg == S_MUL1) ? S_PRED : S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PRED:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    pred_next[i] = pred_sat[i];
                end
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    mcand_next[i] = acc_t'(blend_diff[i]);
                    acc_next[i]   = '0;
                end
                mplier_next = MPLIER_W'(w_reg);
                cnt_next    = '0;
                state_next  = S_MUL2;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        est_next[i] = bypass_reg ? meas_reg[i] : new_est[i];
                    end
                    out_data_next.est_x_out   = bypass_reg ? meas_reg[0] : new_est[0];
                    out_data_next.est_y_out   = bypass_reg ? meas_reg[1] : new_est[1];
                    out_data_next.est_z_out   = bypass_reg ? meas_reg[2] : new_est[2];
                    out_data_next.est_yaw_out = bypass_reg ? meas_reg[3] : new_est[3];
                    out_data_next.roll_out    = roll_reg;
                    out_data_next.pitch_out   = pitch_reg;
                    out_data_next.rejected    = rej_reg & ~bypass_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pending_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            bypass_reg    <= 1'b0;
            step_reg      <= gcpf_pkg::STEP_RESET;
            gate_reg      <= gcpf_pkg::GATE_RESET;
            weight_reg    <= gcpf_pkg::WEIGHT_RESET;
            for (int i = 0; i < LANES; i++)
            begin
                est_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            bypass_reg    <= bypass_next;
            step_reg      <= step_next;
            gate_reg      <= gate_next;
            weight_reg    <= weight_next;
            for (int i = 0; i < LANES; i++)
            begin
                est_reg[i] <= est_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mplier_reg   <= mplier_next;
        roll_reg     <= roll_next;
        pitch_reg    <= pitch_next;
        restart_reg  <= restart_next;
        rej_reg      <= rej_next;
        w_reg        <= w_next;
        out_data_reg <= out_data_next;
        for (int i = 0; i < LANES; i++)
        begin
            meas_reg[i]  <= meas_next[i];
            acc_reg[i]   <= acc_next[i];
            mcand_reg[i] <= mcand_next[i];
            pred_reg[i]  <= pred_next[i];
        end
    end

endmodule

// ===== dv/gcpf_checker.sv =====
`timescale 1ns / 100ps

module gcpf_checker
    import gcpf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  in_item_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     poses_in_flight
);

    localparam longint WORD_HI = (longint'(1) <<< (WORD_W - 1)) - 1;
    localparam longint WORD_LO = -WORD_HI - 1;
    localparam longint Q_ONE   = longint'(1) <<< Q_BITS;

    logic                bypass_r;
    logic [STEP_W-1:0]   step_r;
    logic [GATE_W-1:0]   gate_r;
    logic [WEIGHT_W-1:0] weight_r;
    longint              est[LANES];
    logic                reseed_armed;
    out_item_t           expected_poses[$];

    // New estimate of one axis: saturated prediction, then pulled toward the
    // measurement by w (Q1.16 weight on the prediction), rounded half up.
    function automatic longint blend_axis(longint est_in, longint rate, longint meas,
                                          longint w);
        longint pred;
        pred = est_in + ((rate * longint'(step_r) + Q_HALF) >>> Q_BITS);
        if (pred > WORD_HI)
            pred = WORD_HI;
        else if (pred < WORD_LO)
            pred = WORD_LO;
        return meas + (((pred - meas) * w + Q_HALF) >>> Q_BITS);
    endfunction

    function automatic void check_field(string what, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t gcpf_checker: %s mismatch, expected %h, got %h",
                     $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        longint    meas[LANES];
        longint    rate[LANES];
        longint    offset;
        longint    w;
        logic      gated;
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            bypass_r     = 1'b0;
            step_r       = STEP_RESET;
            gate_r       = GATE_RESET;
            weight_r     = WEIGHT_RESET;
            reseed_armed = 1'b1;
            for (int i = 0; i < LANES; i++)
                est[i] = 0;
            expected_poses.delete();
            mismatches = 0;
            poses_in_flight <= 0;
        end
        else
        begin
            if (cfg_we === 1'b1)
            begin
                case (cfg_index)
                    CFG_BYPASS:       bypass_r = cfg_data[0];
                    CFG_STEP_TIME:    step_r   = cfg_data[STEP_W-1:0];
                    CFG_GATE_LIMIT:   gate_r   = cfg_data[GATE_W-1:0];
                    CFG_BLEND_WEIGHT: weight_r = cfg_data[WEIGHT_W-1:0];
                    default:          ;
                endcase
            end

            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got = out_data;
                if (expected_poses.size() == 0)
                begin
                    mismatches++;
                    $display("%0t gcpf_checker: result beat, expected none, got %h",
                             $time, got);
                end
                else
                begin
                    want = expected_poses.pop_front();
                    check_field("est_x_out", want.est_x_out, got.est_x_out);
                    check_field("est_y_out", want.est_y_out, got.est_y_out);
                    check_field("est_z_out", want.est_z_out, got.est_z_out);
                    check_field("est_yaw_out", want.est_yaw_out, got.est_yaw_out);
                    check_field("roll_out", want.roll_out, got.roll_out);
                    check_field("pitch_out", want.pitch_out, got.pitch_out);
                    check_field("rejected", want.rejected, got.rejected);
                end
            end

            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                meas[0] = $signed(in_data.meas_x);
                meas[1] = $signed(in_data.meas_y);
                meas[2] = $signed(in_data.meas_z);
                meas[3] = $signed(in_data.meas_yaw);
                rate[0] = $signed(in_data.vel_x);
                rate[1] = $signed(in_data.vel_y);
                rate[2] = $signed(in_data.vel_z);
                rate[3] = $signed(in_data.yaw_rate);
                gated = 1'b0;
                w = 0;
                // A restart takes the measurement as is and skips the gate.
                if (in_data.restart === 1'b1 || reseed_armed)
                    reseed_armed = 1'b0;
                else
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        offset = meas[i] - est[i];
                        if (offset < 0)
                            offset = -offset;
                        if (offset > longint'(gate_r))
                            gated = 1'b1;
                    end
                    if (gated || weight_r > WEIGHT_ONE)
                        w = Q_ONE;
                    else
                        w = longint'(weight_r);
                end
                for (int i = 0; i < LANES; i++)
                    est[i] = bypass_r ? meas[i] : blend_axis(est[i], rate[i], meas[i], w);
                if (bypass_r)
                    gated = 1'b0;
                want.est_x_out   = WORD_W'(est[0]);
                want.est_y_out   = WORD_W'(est[1]);
                want.est_z_out   = WORD_W'(est[2]);
                want.est_yaw_out = WORD_W'(est[3]);
                want.roll_out    = in_data.meas_roll;
                want.pitch_out   = in_data.meas_pitch;
                want.rejected    = gated;
                expected_poses.push_back(want);
            end
            poses_in_flight <= expected_poses.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the gated complementary pose filter. The checker
// beside the block watches both channels and the configuration port, keeps
// its own copy of the estimate and compares every result beat.
module tb_top;
    import gcpf_pkg::*;

    // Even with heavy stalls on both sides the run stays far below this ceiling.
    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     SETTLE_CYCLES = 32;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 219;
    localparam longint WORD_HI       = (longint'(1) <<< (WORD_W - 1)) - 1;
    localparam longint WORD_LO       = -WORD_HI - 1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BYPASS;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int     mismatches;
    int     poses_in_flight;
    int     cycles      = 0;
    int     burst_left  = 0;
    logic   sender_calm = 1'b0;
    // Gate currently programmed; it sets how far the test trajectory moves
    // per tick so that most measurements land inside the gate.
    longint gate_now    = longint'(GATE_RESET);
    longint track[LANES];

    gated_complementary_pose_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gcpf_checker pose_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .poses_in_flight (poses_in_flight)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // The receiver stalls on a pattern of its own: stretches of no stall,
    // light and heavy random stall, and solid stall.
    initial
    begin : receiver_pattern
        int mode;
        int len;
        forever
        begin
            mode = $urandom_range(4, 0);
            len  = (mode == 4) ? $urandom_range(30, 2) : $urandom_range(200, 20);
            repeat (len)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(1, 0));
                    2:       out_stall <= ($urandom_range(7, 0) == 0);
                    3:       out_stall <= ($urandom_range(3, 0) != 0);
                    default: out_stall <= 1'b1;
                endcase
            end
        end
    end

    function automatic in_item_t pose(input longint mx, my, mz, myaw, roll, pitch,
                                      input longint vx, vy, vz, vyaw,
                                      input logic restart);
        in_item_t item;
        item.meas_x     = WORD_W'(mx);
        item.meas_y     = WORD_W'(my);
        item.meas_z     = WORD_W'(mz);
        item.meas_yaw   = WORD_W'(myaw);
        item.meas_roll  = WORD_W'(roll);
        item.meas_pitch = WORD_W'(pitch);
        item.vel_x      = WORD_W'(vx);
        item.vel_y      = WORD_W'(vy);
        item.vel_z      = WORD_W'(vz);
        item.yaw_rate   = WORD_W'(vyaw);
        item.restart    = restart;
        return item;
    endfunction

    function automatic longint fit_word(longint v);
        if (v > WORD_HI)
            return WORD_HI;
        if (v < WORD_LO)
            return WORD_LO;
        return v;
    endfunction

    function automatic longint jitter(longint span);
        return longint'($urandom_range(32'(2 * span), 0)) - span;
    endfunction

    // Present one beat and hold it until accepted. Returns at the accepting
    // edge. Bursts of random length alternate with random gaps, except in
    // calm phases where the sender never idles.
    task automatic send_pose(in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = sender_calm ? 0 : $urandom_range(10, 0);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(16, 1);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        burst_left--;
    endtask

    // Stop sending and wait until every result has come back, then let the
    // block settle before anything touches its configuration. One edge is
    // taken first so that the count already includes the last accepted beat.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (poses_in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write, followed by an idle edge so that back-to-back
    // writes never lower and raise the write enable in the same step.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                  pick;
        int                  outlier_lane;
        longint              span;
        longint              gate0;
        longint              meas[LANES];
        longint              vel[LANES];
        logic                restart;
        logic                reseed_next;
        in_item_t            item;
        logic                byp;
        logic [STEP_W-1:0]   st;
        logic [GATE_W-1:0]   gl;
        logic [WEIGHT_W-1:0] bw;

        reseed_next = 1'b0;
        gate0 = longint'(GATE_RESET);
        for (int i = 0; i < LANES; i++)
            track[i] = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part at the default configuration. The very first beat
        // carries no restart request; the restart armed by reset seeds the
        // estimate from it.
        send_pose(pose(WORD_HI, WORD_HI, WORD_HI, WORD_HI, WORD_HI, WORD_LO,
                       WORD_HI, WORD_HI, WORD_HI, WORD_HI, 1'b0));
        // Largest rates on an estimate at the top of the range: the
        // prediction saturates high.
        send_pose(pose(WORD_HI, WORD_HI, WORD_HI, WORD_HI, WORD_LO, WORD_HI,
                       WORD_HI, WORD_HI, WORD_HI, WORD_HI, 1'b0));
        // Requested restart to the bottom, then saturation low.
        send_pose(pose(WORD_LO, WORD_LO, WORD_LO, WORD_LO, 0, 0,
                       WORD_LO, WORD_LO, WORD_LO, WORD_LO, 1'b1));
        send_pose(pose(WORD_LO, WORD_LO, WORD_LO, WORD_LO, 0, 0,
                       WORD_LO, WORD_LO, WORD_LO, WORD_LO, 1'b0));
        // Differences exactly on the gate are still accepted.
        send_pose(pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_pose(pose(gate0, 0, 0, -gate0, 0, 0, 0, 0, 0, 0, 1'b0));
        // One past the gate on one axis, each sign; the y and z beats are rejected.
        send_pose(pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_pose(pose(0, gate0 + 1, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_pose(pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_pose(pose(0, 0, -(gate0 + 1), 0, 0, 0, 65536, -65536, 1 << 20, -(1 << 20),
                       1'b0));
        send_pose(pose(0, 0, 0, -(gate0 + 1), 0, 0, 0, 0, 0, 0, 1'b0));
        // Ordinary blending with rates of both signs.
        send_pose(pose(1000, -2000, 300, 5, 0, 0, 0, 0, 0, 0, 1'b1));
        send_pose(pose(1500, -2600, 900, -40, 12345, -12345,
                       65536, -65536, 1 << 20, -(1 << 20), 1'b0));
        // Alternating bit patterns on every field.
        send_pose(pose('h5555_5555, 'h5555_5555, 'h5555_5555, 'h5555_5555, 'h5555_5555,
                       'h5555_5555, 'h5555_5555, 'h5555_5555, 'h5555_5555, 'h5555_5555,
                       1'b1));
        send_pose(pose('hAAAA_AAAA, 'hAAAA_AAAA, 'hAAAA_AAAA, 'hAAAA_AAAA, 'hAAAA_AAAA,
                       'hAAAA_AAAA, 'hAAAA_AAAA, 'hAAAA_AAAA, 'hAAAA_AAAA, 'hAAAA_AAAA,
                       1'b0));
        // Arm a restart so the estimate is reseeded for the random part.
        reseed_next = 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            // Phase 0 keeps the reset configuration. Later phases drain the
            // block and load a new setting: zero step time with weight zero,
            // largest step time with weight one, bypass, a closed gate, a
            // fully open gate, a weight above one and random values. Upper
            // bits of the write data are garbage that the block must drop.
            if (p > 0)
            begin
                drain();
                byp = (p == 3) || (p == 7 && $urandom_range(1, 0) == 1);
                case (p)
                    1:       st = '0;
                    2:       st = '1;
                    5:       st = STEP_RESET;
                    default: st = STEP_W'($urandom);
                endcase
                case (p)
                    4:       gl = '0;
                    5:       gl = '1;
                    default: gl = GATE_W'($urandom_range(2_000_000, 1000));
                endcase
                case (p)
                    1:       bw = WEIGHT_ZERO;
                    2:       bw = WEIGHT_ONE;
                    6:       bw = '1;
                    7:       bw = WEIGHT_W'($urandom_range(131071, 65537));
                    default: bw = WEIGHT_W'($urandom_range(65536, 0));
                endcase
                write_reg(CFG_BYPASS, {23'($urandom), byp});
                write_reg(CFG_STEP_TIME, {8'($urandom), st});
                write_reg(CFG_GATE_LIMIT, gl);
                write_reg(CFG_BLEND_WEIGHT, {7'($urandom), bw});
                gate_now = longint'(gl);
                sender_calm = ($urandom_range(3, 0) == 0);
            end

            // Random part: mostly a smooth trajectory that stays inside the
            // gate, with outliers on one axis, occasional restarts that may
            // jump anywhere in the range, and some beats of pure noise.
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99, 0);
                span = gate_now / 8 + 1;
                if (pick < 5)
                begin
                    item = pose($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom, $urandom,
                                1'($urandom_range(1, 0)));
                    // A noisy restart would leave the estimate far off the
                    // trajectory, so the next beat seeds it again.
                    reseed_next = item.restart;
                end
                else
                begin
                    restart = reseed_next || pick >= 97;
                    reseed_next = 1'b0;
                    for (int i = 0; i < LANES; i++)
                    begin
                        if (restart && $urandom_range(1, 0) == 1)
                            track[i] = longint'($signed($urandom));
                        else
                            track[i] = fit_word(track[i] + jitter(span));
                        meas[i] = track[i];
                        vel[i]  = jitter(span);
                    end
                    if (pick < 13 && !restart)
                    begin
                        outlier_lane = $urandom_range(LANES - 1, 0);
                        meas[outlier_lane] = fit_word(track[outlier_lane] +
                            ($urandom_range(1, 0) == 1 ? 1 : -1) *
                            (gate_now + 1 + longint'($urandom_range(1 << 20, 0))));
                    end
                    item = pose(meas[0], meas[1], meas[2], meas[3], $urandom, $urandom,
                                vel[0], vel[1], vel[2], vel[3], restart);
                end
                send_pose(item);
            end
        end

        drain();
        if (mismatches == 0 && poses_in_flight == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/gcpf_pkg.sv
hw/rtl/gated_complementary_pose_filter.sv
dv/gcpf_checker.sv
dv/tb_top.sv
